[src/bsit_pkg.sv]
`default_nettype none
package bsit_pkg;

    localparam int SLOTS     = 256;
    localparam int WORDS     = 8;
    localparam int WORD_BITS = 32;
    localparam int BUCKETS   = 256;

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int LINK_W  = SLOT_W + 1;
    localparam int WIDX_W  = $clog2(WORDS);
    localparam int WCNT_W  = WIDX_W + 1;
    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int BCNT_W  = BKT_W + 1;
    localparam int DCNT_W  = $clog2(WORD_BITS);
    localparam int ADDR_W  = 3;

    localparam logic [LINK_W-1:0] NIL_LINK    = LINK_W'(SLOTS);
    localparam logic [BCNT_W-1:0] BUCKETS_RST = BCNT_W'(251);
    localparam logic [3:0]        WORDS_RST   = 4'd8;

    // register index, taken from paddr[2]
    localparam logic REG_BUCKET_COUNT = 1'b0;
    localparam logic REG_WORDS_IN_USE = 1'b1;

    typedef enum logic [1:0] {
        REQ_CLAIM  = 2'd0,
        REQ_WRITE  = 2'd1,
        REQ_INTERN = 2'd2,
        REQ_UNSET  = 2'd3
    } t_req;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [SLOT_W-1:0]    slot;
        logic [WIDX_W-1:0]    word_index;
        logic [WORD_BITS-1:0] word_value;
    } t_in_beat;

    typedef struct packed {
        logic [SLOT_W-1:0] result_slot;
        logic              flag;
    } t_out_beat;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_WR,
        S_U_SRD, S_U_SLD, S_U_CHK, S_U_NXT, S_U_END,
        S_DIV_INIT, S_DIV, S_HEAD_RD, S_HEAD_LD,
        S_I_CLR, S_I_RD, S_I_ACC, S_I_CHK, S_I_CMP, S_I_WRD, S_I_WACC,
        S_I_INS1, S_I_INS2, S_DONE
    } t_state;

    typedef struct packed {
        logic lat_req;
        logic wr_word;
        logic rd_w;
        logic w_cur;
        logic rd_sig;
        logic sig_cur;
        logic rd_nl;
        logic sig_ld_rd;
        logic fold_clr;
        logic fold_acc;
        logic i_clr;
        logic i_inc;
        logic div_init;
        logic div_step;
        logic rd_head;
        logic ld_cur_head;
        logic adv;
        logic unlink_wr;
        logic clr_pooled;
        logic ins_nl;
        logic ins_link;
        logic flag_set;
        logic set_res_cur;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] req;
        logic       pooled_s;
        logic       cur_nil;
        logic       cur_is_s;
        logic       n_done;
        logic       sig_gt;
        logic       sig_eq;
        logic       word_eq;
        logic       i_last;
        logic       div_last;
        logic       out_busy;
    } t_sts;

endpackage
`default_nettype wire

[src/bsit_dp.sv]
`default_nettype none
module bsit_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire bsit_pkg::t_in_beat          i_in_beat,
    input  wire logic [bsit_pkg::BCNT_W-1:0] i_bucket_count,
    input  wire logic [3:0]                  i_words_in_use,
    input  wire logic                        i_flush,
    input  wire bsit_pkg::t_cmd              i_cmd,
    output bsit_pkg::t_sts                   o_sts,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output bsit_pkg::t_out_beat              o_out_beat
);
    import bsit_pkg::*;

    logic [WORD_BITS-1:0] m_words [SLOTS*WORDS];
    logic [WORD_BITS-1:0] m_sig   [SLOTS];
    logic [LINK_W-1:0]    m_nl    [SLOTS];
    logic [LINK_W-1:0]    m_head  [BUCKETS];
    logic [BUCKETS-1:0]   r_hvld;
    logic [SLOTS-1:0]     r_pooled;

    t_in_beat             r_req;
    logic [WORD_BITS-1:0] r_w_rd, r_sig_rd, r_sig, r_dvd;
    logic [WORD_BITS-1:0] r_mine [WORDS];
    logic [LINK_W-1:0]    r_nl_rd, r_hd, r_cur, r_prev;
    logic                 r_hv;
    logic [BCNT_W-1:0]    r_n, r_rem, eff_b, rem_sh;
    logic [WCNT_W-1:0]    r_i;
    logic [3:0]           eff_w;
    logic [DCNT_W-1:0]    r_dcnt;
    logic [SLOT_W-1:0]    r_res;
    logic                 r_flag, r_out_valid;
    t_out_beat            r_out;

    logic [SLOT_W+WIDX_W-1:0] w_addr;
    logic [SLOT_W-1:0]        sig_addr, nl_waddr;
    logic [BKT_W-1:0]         b_addr;
    logic                     prev_nil, nl_we, hd_we;
    logic [LINK_W-1:0]        nl_wdata, hd_wdata, slot_link;

    always_comb begin
        if (i_bucket_count == '0) eff_b = BCNT_W'(1);
        else if (i_bucket_count > BCNT_W'(BUCKETS)) eff_b = BCNT_W'(BUCKETS);
        else eff_b = i_bucket_count;
        if (i_words_in_use == '0) eff_w = 4'd1;
        else if (i_words_in_use > 4'(WORDS)) eff_w = 4'(WORDS);
        else eff_w = i_words_in_use;
    end

    assign slot_link = {1'b0, r_req.slot};
    assign prev_nil  = r_prev[LINK_W-1];
    assign b_addr    = r_rem[BKT_W-1:0];
    assign w_addr    = {(i_cmd.w_cur ? r_cur[SLOT_W-1:0] : r_req.slot), r_i[WIDX_W-1:0]};
    assign sig_addr  = i_cmd.sig_cur ? r_cur[SLOT_W-1:0] : r_req.slot;
    assign rem_sh    = {r_rem[BKT_W-1:0], r_dvd[WORD_BITS-1]};

    // link writes: unlink bypass, new node's forward link, predecessor update
    assign nl_we    = ((i_cmd.unlink_wr | i_cmd.ins_link) & !prev_nil) | i_cmd.ins_nl;
    assign nl_waddr = i_cmd.ins_nl ? r_req.slot : r_prev[SLOT_W-1:0];
    assign nl_wdata = i_cmd.unlink_wr ? r_nl_rd :
                      i_cmd.ins_nl ? (r_cur[LINK_W-1] ? NIL_LINK : r_cur) : slot_link;
    assign hd_we    = (i_cmd.unlink_wr | i_cmd.ins_link) & prev_nil;
    assign hd_wdata = i_cmd.unlink_wr ? r_nl_rd : slot_link;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_word) m_words[{r_req.slot, r_req.word_index}] <= r_req.word_value;
        if (i_cmd.rd_w) r_w_rd <= m_words[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_link) m_sig[r_req.slot] <= r_sig;
        if (i_cmd.rd_sig) r_sig_rd <= m_sig[sig_addr];
    end

    always_ff @(posedge i_clk) begin
        if (nl_we) m_nl[nl_waddr] <= nl_wdata;
        if (i_cmd.rd_nl) r_nl_rd <= m_nl[r_cur[SLOT_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (hd_we) m_head[b_addr] <= hd_wdata;
        if (i_cmd.rd_head) begin
            r_hd <= m_head[b_addr];
            r_hv <= r_hvld[b_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_hvld   <= '0;
            r_pooled <= '0;
        end else begin
            if (hd_we) r_hvld[b_addr] <= 1'b1;
            if (i_cmd.clr_pooled) r_pooled[r_req.slot] <= 1'b0;
            if (i_cmd.ins_link) r_pooled[r_req.slot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_req) begin
            r_req  <= i_in_beat;
            r_res  <= i_in_beat.slot;
            r_flag <= 1'b0;
        end
        if (i_cmd.set_res_cur) r_res <= r_cur[SLOT_W-1:0];
        if (i_cmd.flag_set) r_flag <= 1'b1;

        if (i_cmd.sig_ld_rd) r_sig <= r_sig_rd;
        else if (i_cmd.fold_clr) r_sig <= '0;
        else if (i_cmd.fold_acc) r_sig <= r_sig ^ r_w_rd;
        if (i_cmd.fold_acc) r_mine[r_i[WIDX_W-1:0]] <= r_w_rd;

        if (i_cmd.i_clr) r_i <= '0;
        else if (i_cmd.i_inc) r_i <= r_i + WCNT_W'(1);

        // restoring remainder, one dividend bit per beat of the counter
        if (i_cmd.div_init) begin
            r_dvd  <= r_sig;
            r_rem  <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd  <= {r_dvd[WORD_BITS-2:0], 1'b0};
            r_rem  <= (rem_sh >= eff_b) ? rem_sh - eff_b : rem_sh;
            r_dcnt <= r_dcnt + DCNT_W'(1);
        end

        if (i_cmd.ld_cur_head) begin
            r_cur  <= r_hv ? r_hd : NIL_LINK;
            r_prev <= NIL_LINK;
            r_n    <= '0;
        end else if (i_cmd.adv) begin
            r_prev <= r_cur;
            r_cur  <= r_nl_rd;
            r_n    <= r_n + BCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.result_slot <= r_res;
            r_out.flag        <= r_flag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    always_comb begin
        o_sts.req      = r_req.req_type;
        o_sts.pooled_s = r_pooled[r_req.slot];
        o_sts.cur_nil  = r_cur[LINK_W-1];
        o_sts.cur_is_s = (r_cur == slot_link);
        o_sts.n_done   = r_n[BCNT_W-1];
        o_sts.sig_gt   = (r_sig_rd > r_sig);
        o_sts.sig_eq   = (r_sig_rd == r_sig);
        o_sts.word_eq  = (r_w_rd == r_mine[r_i[WIDX_W-1:0]]);
        o_sts.i_last   = ((r_i + WCNT_W'(1)) == WCNT_W'(eff_w));
        o_sts.div_last = (r_dcnt == DCNT_W'(WORD_BITS - 1));
        o_sts.out_busy = r_out_valid;
    end
endmodule
`default_nettype wire

[src/bsit_ctrl.sv]
`default_nettype none
module bsit_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire bsit_pkg::t_sts i_sts,
    output bsit_pkg::t_cmd      o_cmd
);
    import bsit_pkg::*;

    t_state r_state, n_state;
    logic   r_unl, n_unl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_unl   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_unl   <= n_unl;
        end
    end

    always_comb begin
        n_state = r_state;
        n_unl   = r_unl;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_DISP;
            S_DISP: begin
                case (t_req'(i_sts.req))
                    REQ_WRITE:  n_state = S_WR;
                    REQ_INTERN: n_state = i_sts.pooled_s ? S_U_SRD : S_I_CLR;
                    default:    n_state = i_sts.pooled_s ? S_U_SRD : S_DONE;
                endcase
                n_unl = i_sts.pooled_s;
            end
            S_WR:       n_state = S_DONE;
            S_U_SRD:    n_state = S_U_SLD;
            S_U_SLD:    n_state = S_DIV_INIT;
            S_DIV_INIT: n_state = S_DIV;
            S_DIV:      if (i_sts.div_last) n_state = S_HEAD_RD;
            S_HEAD_RD:  n_state = S_HEAD_LD;
            S_HEAD_LD:  n_state = r_unl ? S_U_CHK : S_I_CHK;
            S_U_CHK:    n_state = (i_sts.n_done || i_sts.cur_nil) ? S_U_END : S_U_NXT;
            S_U_NXT:    n_state = i_sts.cur_is_s ? S_U_END : S_U_CHK;
            S_U_END: begin
                n_unl   = 1'b0;
                n_state = (t_req'(i_sts.req) == REQ_INTERN) ? S_I_CLR : S_DONE;
            end
            S_I_CLR:    n_state = S_I_RD;
            S_I_RD:     n_state = S_I_ACC;
            S_I_ACC:    n_state = i_sts.i_last ? S_DIV_INIT : S_I_RD;
            S_I_CHK:    n_state = (i_sts.n_done || i_sts.cur_nil) ? S_I_INS1 : S_I_CMP;
            S_I_CMP: begin
                if (i_sts.sig_gt) n_state = S_I_INS1;
                else if (i_sts.sig_eq) n_state = S_I_WRD;
                else n_state = S_I_CHK;
            end
            S_I_WRD:    n_state = S_I_WACC;
            S_I_WACC: begin
                if (!i_sts.word_eq) n_state = S_I_CHK;
                else if (i_sts.i_last) n_state = S_DONE;
                else n_state = S_I_WRD;
            end
            S_I_INS1:   n_state = S_I_INS2;
            S_I_INS2:   n_state = S_DONE;
            S_DONE:     if (!i_sts.out_busy) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE:     o_cmd.lat_req = i_in_valid;
            S_WR:       o_cmd.wr_word = 1'b1;
            S_U_SRD:    o_cmd.rd_sig = 1'b1;
            S_U_SLD:    o_cmd.sig_ld_rd = 1'b1;
            S_DIV_INIT: o_cmd.div_init = 1'b1;
            S_DIV:      o_cmd.div_step = 1'b1;
            S_HEAD_RD:  o_cmd.rd_head = 1'b1;
            S_HEAD_LD:  o_cmd.ld_cur_head = 1'b1;
            S_U_CHK:    o_cmd.rd_nl = !(i_sts.n_done || i_sts.cur_nil);
            S_U_NXT: begin
                if (i_sts.cur_is_s) begin
                    o_cmd.unlink_wr = 1'b1;
                    o_cmd.flag_set  = (t_req'(i_sts.req) == REQ_UNSET);
                end else begin
                    o_cmd.adv = 1'b1;
                end
            end
            S_U_END:    o_cmd.clr_pooled = 1'b1;
            S_I_CLR: begin
                o_cmd.fold_clr = 1'b1;
                o_cmd.i_clr    = 1'b1;
            end
            S_I_RD:     o_cmd.rd_w = 1'b1;
            S_I_ACC: begin
                o_cmd.fold_acc = 1'b1;
                o_cmd.i_inc    = 1'b1;
            end
            S_I_CHK: begin
                o_cmd.rd_sig  = !(i_sts.n_done || i_sts.cur_nil);
                o_cmd.sig_cur = 1'b1;
                o_cmd.rd_nl   = !(i_sts.n_done || i_sts.cur_nil);
            end
            S_I_CMP: begin
                o_cmd.i_clr = !i_sts.sig_gt && i_sts.sig_eq;
                o_cmd.adv   = !i_sts.sig_gt && !i_sts.sig_eq;
            end
            S_I_WRD: begin
                o_cmd.rd_w  = 1'b1;
                o_cmd.w_cur = 1'b1;
            end
            S_I_WACC: begin
                if (!i_sts.word_eq) o_cmd.adv = 1'b1;
                else if (i_sts.i_last) o_cmd.set_res_cur = 1'b1;
                else o_cmd.i_inc = 1'b1;
            end
            S_I_INS1:   o_cmd.ins_nl = 1'b1;
            S_I_INS2: begin
                o_cmd.ins_link = 1'b1;
                o_cmd.flag_set = 1'b1;
            end
            S_DONE:     o_cmd.out_load = !i_sts.out_busy;
            default:    o_cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

[src/bitset_interning_table.sv]
// a write, or a claim of an unpooled slot, touches no chain; an unlink walks the slot's bucket chain
// intern folds words_in_use words into a signature, walks its bucket chain and compares words on a signature match
// the bit-serial remainder unit and the single-port chain memories pace each request
// one request at a time; a new beat is taken while the previous result waits at the output
// reset (synchronous, active low) empties all buckets and pooled bits at once, no clearing pass
// writing bucket_count empties the pool the same way
`default_nettype none
module bitset_interning_table (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire bsit_pkg::t_in_beat            i_in_beat,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output bsit_pkg::t_out_beat                o_out_beat,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bsit_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import bsit_pkg::*;

    logic [BCNT_W-1:0] r_bucket_count;
    logic [3:0]        r_words_in_use;
    logic              cfg_wr, flush;
    t_cmd              cmd;
    t_sts              sts;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign flush  = cfg_wr & (paddr[2] == REG_BUCKET_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= BUCKETS_RST;
            r_words_in_use <= WORDS_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_BUCKET_COUNT) r_bucket_count <= pwdata[BCNT_W-1:0];
            else r_words_in_use <= pwdata[3:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_BUCKET_COUNT) prdata = {{(32-BCNT_W){1'b0}}, r_bucket_count};
        else prdata = {28'd0, r_words_in_use};
    end

    bsit_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bsit_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_beat      (i_in_beat),
        .i_bucket_count (r_bucket_count),
        .i_words_in_use (r_words_in_use),
        .i_flush        (flush),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_beat     (o_out_beat)
    );
endmodule
`default_nettype wire
